// ----- hw/rtl/fae_pkg.sv -----
package fae_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int HEADER_BYTES    = 16;

  // Every frame position and length fits these widths over the whole
  // supported buffer range.
  localparam int POS_W = 6;
  localparam int LEN_W = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = 2;
  localparam int QUEUE_CW    = 3;

  // Command selector codes on the request channel.
  localparam logic [3:0] FN_NOP    = 4'd0;
  localparam logic [3:0] FN_CLEAR  = 4'd1;
  localparam logic [3:0] FN_PROTO  = 4'd2;
  localparam logic [3:0] FN_SET8   = 4'd3;
  localparam logic [3:0] FN_SET16  = 4'd4;
  localparam logic [3:0] FN_PLEN   = 4'd5;
  localparam logic [3:0] FN_APPEND = 4'd6;
  localparam logic [3:0] FN_SEND   = 4'd7;
  localparam logic [3:0] FN_PRINT  = 4'd8;
  localparam logic [3:0] FN_HALT   = 4'd9;

  // Classified operations handed from the front end to the back end.
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_PROTO  = 4'd2;
  localparam logic [3:0] OP_SET8   = 4'd3;
  localparam logic [3:0] OP_SET16  = 4'd4;
  localparam logic [3:0] OP_APPEND = 4'd5;
  localparam logic [3:0] OP_SEND   = 4'd6;
  localparam logic [3:0] OP_HALT   = 4'd7;
  localparam logic [3:0] OP_BAD    = 4'd8;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] offset;
    logic [15:0] value;
    logic [7:0]  payload_byte;
    logic [15:0] payload_len;
    logic        has_payload;
    logic        payload_last;
    logic        program_start;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] frame_byte;
    logic       last;
    logic [6:0] frame_length;
    logic [1:0] error_code;
    logic       halted;
  } out_item_t;

  typedef struct packed {
    logic [3:0]       op;
    logic             start;
    logic [POS_W-1:0] pos;
    logic [15:0]      data;
    logic [LEN_W-1:0] plen;
    logic             p_skip;
    logic             p_big;
    logic             p_last;
  } cmd_t;

endpackage

// ----- hw/rtl/fae_ram.sv -----
module fae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/fae_front.sv -----
module fae_front #(
  parameter int FRAME_BYTES = fae_pkg::FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  fae_pkg::in_item_t cmd,
  output logic              q_valid,
  input  logic              q_pop,
  output fae_pkg::cmd_t     q_cmd
);

  localparam logic [15:0] FB_W16  = 16'(FRAME_BYTES);
  localparam logic [15:0] MAX_U16 = 16'(FRAME_BYTES - 2);

  fae_pkg::cmd_t dec;
  fae_pkg::cmd_t q_mem [fae_pkg::QUEUE_DEPTH];

  logic [fae_pkg::QUEUE_PW-1:0] wr_ptr;
  logic [fae_pkg::QUEUE_PW-1:0] rd_ptr;
  logic [fae_pkg::QUEUE_CW-1:0] count;
  logic                         push;

  // Field writes that fall outside the buffer are turned into no-ops here,
  // so the back end only ever sees positions that are in range.
  always_comb begin
    dec        = '0;
    dec.start  = cmd.program_start;
    dec.pos    = cmd.offset[fae_pkg::POS_W-1:0];
    dec.p_skip = !cmd.has_payload || (cmd.payload_len == 16'd0);
    dec.p_big  = cmd.payload_len > FB_W16;
    dec.plen   = cmd.payload_len[fae_pkg::LEN_W-1:0];
    dec.p_last = cmd.payload_last;
    case (cmd.func)
      fae_pkg::FN_NOP, fae_pkg::FN_PRINT: begin
        dec.op = fae_pkg::OP_NOP;
      end
      fae_pkg::FN_CLEAR: begin
        dec.op = fae_pkg::OP_CLEAR;
      end
      fae_pkg::FN_PROTO: begin
        dec.op   = fae_pkg::OP_PROTO;
        dec.pos  = '0;
        dec.data = {8'h00, cmd.offset[7:0]};
      end
      fae_pkg::FN_SET8: begin
        dec.op   = (cmd.offset < FB_W16) ? fae_pkg::OP_SET8 : fae_pkg::OP_NOP;
        dec.data = {8'h00, cmd.value[7:0]};
      end
      fae_pkg::FN_SET16: begin
        dec.op   = (cmd.offset <= MAX_U16) ? fae_pkg::OP_SET16 : fae_pkg::OP_NOP;
        dec.data = cmd.value;
      end
      fae_pkg::FN_PLEN: begin
        dec.op   = (cmd.has_payload && (cmd.offset <= MAX_U16)) ?
                   fae_pkg::OP_SET16 : fae_pkg::OP_NOP;
        dec.data = cmd.payload_len;
      end
      fae_pkg::FN_APPEND: begin
        dec.op   = fae_pkg::OP_APPEND;
        dec.data = {8'h00, cmd.payload_byte};
      end
      fae_pkg::FN_SEND: begin
        dec.op = fae_pkg::OP_SEND;
      end
      fae_pkg::FN_HALT: begin
        dec.op = fae_pkg::OP_HALT;
      end
      default: begin
        dec.op = fae_pkg::OP_BAD;
      end
    endcase
  end

  assign cmd_ready = count != fae_pkg::QUEUE_CW'(fae_pkg::QUEUE_DEPTH);
  assign push      = cmd_valid && cmd_ready;
  assign q_valid   = count != '0;
  assign q_cmd     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/fae_back.sv -----
module fae_back #(
  parameter int FRAME_BYTES = fae_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  fae_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output fae_pkg::out_item_t res
);

  localparam int IW         = $clog2(FRAME_BYTES);
  localparam int BANK_DEPTH = (FRAME_BYTES + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int LW         = fae_pkg::LEN_W;
  localparam logic [LW-1:0] FB_LEN = LW'(FRAME_BYTES);

  localparam logic ST_CMD  = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic                   state, state_next;
  logic [LW-1:0]          len, len_next;
  logic                   halt, halt_next;
  logic [1:0]             err, err_next;
  logic                   app, app_next;
  logic [FRAME_BYTES-1:0] valid, valid_next;
  logic [LW-1:0]          rd_idx, rd_idx_next;
  logic                   pend, pend_next;
  logic [LW-1:0]          pend_idx, pend_idx_next;
  logic                   pend_wr, pend_wr_next;

  logic                   out_free;
  logic                   out_load;
  fae_pkg::out_item_t     out_next;

  // One or two byte writes per command: byte A at wr_a, byte B after it.
  logic                   wr_en;
  logic                   wr_two;
  logic [LW-1:0]          wr_a;
  logic [LW-1:0]          wr_a1;
  logic [7:0]             wr_da;
  logic [7:0]             wr_db;

  logic                   ev_we, od_we;
  logic [BANK_AW-1:0]     ev_waddr, od_waddr;
  logic [7:0]             ev_wdata, od_wdata;
  logic                   rd_en;
  logic [7:0]             ev_q, od_q;

  logic [LW:0]            app_sum;
  logic                   app_go;
  logic                   load;
  logic                   issue;
  logic                   is_last;

  // These are taken straight from the queue head, the registered length and the result handshake, so
  // the command logic below never feeds back into them.
  assign out_free = !res_valid || res_ready;
  assign wr_a1    = {1'b0, q_cmd.pos} + 1'b1;
  assign app_sum  = {1'b0, (q_cmd.start ? LW'(0) : len)} + {1'b0, q_cmd.plen};

  always_comb begin
    state_next    = state;
    len_next      = len;
    halt_next     = halt;
    err_next      = err;
    app_next      = app;
    valid_next    = valid;
    rd_idx_next   = rd_idx;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    pend_wr_next  = pend_wr;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_next      = '0;
    wr_en         = 1'b0;
    wr_two        = 1'b0;
    wr_a          = '0;
    wr_da         = q_cmd.data[7:0];
    wr_db         = q_cmd.data[7:0];
    rd_en         = 1'b0;
    app_go        = 1'b0;
    load          = 1'b0;
    issue         = 1'b0;
    is_last       = 1'b0;

    case (state)
      ST_CMD: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          if (q_cmd.start) begin
            len_next   = '0;
            halt_next  = 1'b0;
            err_next   = fae_pkg::ERR_NONE;
            app_next   = 1'b0;
            valid_next = '0;
          end
          // A halted or failed program ignores everything up to the next start.
          if (!halt_next && (err_next == fae_pkg::ERR_NONE)) begin
            if (q_cmd.op != fae_pkg::OP_APPEND) begin
              app_next = 1'b0;
            end
            case (q_cmd.op)
              fae_pkg::OP_CLEAR: begin
                len_next = '0;
                for (int i = 0; i < fae_pkg::HEADER_BYTES; i++) begin
                  valid_next[i] = 1'b0;
                end
              end
              fae_pkg::OP_PROTO: begin
                wr_en = 1'b1;
                valid_next[0] = 1'b1;
                if (len_next == '0) begin
                  len_next = LW'(1);
                end
              end
              fae_pkg::OP_SET8: begin
                wr_en = 1'b1;
                wr_a  = {1'b0, q_cmd.pos};
                valid_next[wr_a[IW-1:0]] = 1'b1;
                if (len_next < wr_a1) begin
                  len_next = wr_a1;
                end
              end
              fae_pkg::OP_SET16: begin
                wr_en  = 1'b1;
                wr_two = 1'b1;
                wr_a   = {1'b0, q_cmd.pos};
                wr_da  = q_cmd.data[15:8];
                valid_next[wr_a[IW-1:0]]  = 1'b1;
                valid_next[wr_a1[IW-1:0]] = 1'b1;
                if (len_next < wr_a1 + 1'b1) begin
                  len_next = wr_a1 + 1'b1;
                end
              end
              fae_pkg::OP_APPEND: begin
                if (app_next) begin
                  app_go = 1'b1;
                end else if (!q_cmd.p_skip) begin
                  if (q_cmd.p_big || (app_sum > {1'b0, FB_LEN})) begin
                    err_next = fae_pkg::ERR_OVERFLOW;
                  end else begin
                    app_go = 1'b1;
                  end
                end
                if (app_go) begin
                  // Within an open run a byte beyond the buffer is dropped.
                  if (len_next < FB_LEN) begin
                    wr_en = 1'b1;
                    wr_a  = len_next;
                    valid_next[len_next[IW-1:0]] = 1'b1;
                    len_next = len_next + 1'b1;
                  end
                  app_next = !q_cmd.p_last;
                end
              end
              fae_pkg::OP_SEND: begin
                if (len_next != '0) begin
                  out_load    = 1'b0;
                  state_next  = ST_SEND;
                  rd_idx_next = '0;
                  pend_next   = 1'b0;
                end
              end
              fae_pkg::OP_HALT: begin
                halt_next = 1'b1;
              end
              fae_pkg::OP_BAD: begin
                err_next = fae_pkg::ERR_UNKNOWN;
              end
              default: begin
              end
            endcase
          end
          out_next.out_kind     = 1'b0;
          out_next.frame_byte   = 8'h00;
          out_next.last         = 1'b1;
          out_next.frame_length = len_next;
          out_next.error_code   = err_next;
          out_next.halted       = halt_next;
        end
      end
      ST_SEND: begin
        // Read of byte i+1 overlaps delivery of byte i; the RAM output holds
        // while the result register is stalled.
        load  = pend && out_free;
        issue = (rd_idx < len) && (!pend || load);
        if (load) begin
          is_last               = (pend_idx + 1'b1) == len;
          out_load              = 1'b1;
          out_next.out_kind     = 1'b1;
          out_next.frame_byte   = pend_wr ? (pend_idx[0] ? od_q : ev_q) : 8'h00;
          out_next.last         = is_last;
          out_next.frame_length = len;
          out_next.error_code   = err;
          out_next.halted       = halt;
          if (is_last) begin
            state_next = ST_CMD;
          end
        end
        if (issue) begin
          rd_en         = 1'b1;
          rd_idx_next   = rd_idx + 1'b1;
          pend_idx_next = rd_idx;
          pend_wr_next  = valid[rd_idx[IW-1:0]];
          pend_next     = 1'b1;
        end else if (load) begin
          pend_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_CMD;
      end
    endcase
  end

  // Even positions live in one bank and odd ones in the other, so both bytes of a
  // 16-bit field are written in the same cycle.
  always_comb begin
    ev_we    = wr_en && (!wr_a[0] || wr_two);
    ev_waddr = wr_a[0] ? wr_a1[BANK_AW:1] : wr_a[BANK_AW:1];
    ev_wdata = wr_a[0] ? wr_db : wr_da;
    od_we    = wr_en && (wr_a[0] || wr_two);
    od_waddr = wr_a[BANK_AW:1];
    od_wdata = wr_a[0] ? wr_da : wr_db;
  end

  fae_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH)
  ) u_even (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .re    (rd_en),
    .raddr (rd_idx[BANK_AW:1]),
    .rdata (ev_q)
  );

  fae_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH)
  ) u_odd (
    .clk   (clk),
    .we    (od_we),
    .waddr (od_waddr),
    .wdata (od_wdata),
    .re    (rd_en),
    .raddr (rd_idx[BANK_AW:1]),
    .rdata (od_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CMD;
      len       <= '0;
      halt      <= 1'b0;
      err       <= fae_pkg::ERR_NONE;
      app       <= 1'b0;
      valid     <= '0;
      rd_idx    <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      len    <= len_next;
      halt   <= halt_next;
      err    <= err_next;
      app    <= app_next;
      valid  <= valid_next;
      rd_idx <= rd_idx_next;
      pend   <= pend_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    pend_wr  <= pend_wr_next;
    if (out_load) begin
      res <= out_next;
    end
  end

endmodule

// ----- hw/rtl/frame_assembly_engine_unit.sv -----
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+---------------------
// request   | in        | cmd_valid / cmd_ready | cmd (fae_pkg::in_item_t)
// result    | out       | res_valid / res_ready | res (fae_pkg::out_item_t)
//
// Requests go into a four-entry queue, one per cycle until it is full.
// A non-send command is written into the queue on acceptance and popped from its head, and
// its status result is registered on the same edge as the pop. A send of L bytes is popped,
// then its first byte is read, then the bytes go out one per cycle while the result side
// does not stall. Synchronous reset clears the queue, the length, the flags and the
// written marks, not the buffer. A result stall backs up through the queue.
module frame_assembly_engine_unit #(
  parameter int FRAME_BYTES = fae_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  fae_pkg::in_item_t  cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output fae_pkg::out_item_t res
);

  logic          q_valid;
  logic          q_pop;
  fae_pkg::cmd_t q_cmd;

  fae_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd)
  );

  fae_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ----- sim/tb_frame_assembly_engine_unit.sv -----
module tb_frame_assembly_engine_unit;

  localparam int FB            = fae_pkg::FRAME_BYTES_DEF;
  localparam int RANDOM_ITEMS  = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 250;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    fae_pkg::in_item_t  r;
    logic               fixed;
    fae_pkg::out_item_t want;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_ready;
  fae_pkg::in_item_t  cmd;
  logic               res_valid;
  logic               res_ready;
  fae_pkg::out_item_t res;

  frame_assembly_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Predicted frame context.
  logic [7:0]  frame_mem [FB];
  bit          written_mask [FB];
  int unsigned pred_len;
  bit          halt_seen;
  logic [1:0]  err_state;
  bit          run_open;

  fae_pkg::out_item_t pending_beats [$];
  int          errors;
  int          items_done;
  int          n_directed;
  int          beats_seen;
  int          frames_sent;
  int          burst_left;
  bit          want_hold;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void wipe_context();
    for (int i = 0; i < FB; i++) begin
      frame_mem[i]    = 8'h00;
      written_mask[i] = 1'b0;
    end
    pred_len  = 0;
    halt_seen = 1'b0;
    err_state = fae_pkg::ERR_NONE;
    run_open  = 1'b0;
  endfunction

  function automatic void store_byte(int unsigned pos, logic [7:0] v);
    if (pos < FB) begin
      frame_mem[pos]    = v;
      written_mask[pos] = 1'b1;
    end
  endfunction

  function automatic void grow_to(int unsigned n);
    if (pred_len < n) pred_len = n;
  endfunction

  function automatic void store_u16(int unsigned off, logic [15:0] v);
    if (off + 2 <= FB) begin
      store_byte(off, v[15:8]);
      store_byte(off + 1, v[7:0]);
      grow_to(off + 2);
    end
  endfunction

  function automatic fae_pkg::out_item_t beat_of(logic kind, logic [7:0] b, logic lst);
    fae_pkg::out_item_t o;
    o.out_kind     = kind;
    o.frame_byte   = b;
    o.last         = lst;
    o.frame_length = pred_len[6:0];
    o.error_code   = err_state;
    o.halted       = halt_seen;
    return o;
  endfunction

  // Applies one request to the predicted context and queues the beats it causes.
  function automatic void predict_frame_cmd(fae_pkg::in_item_t r);
    if (r.program_start) wipe_context();
    if (halt_seen || err_state != fae_pkg::ERR_NONE) begin
      pending_beats.push_back(beat_of(1'b0, 8'h00, 1'b1));
      return;
    end
    if (r.func != fae_pkg::FN_APPEND) run_open = 1'b0;
    case (r.func)
      fae_pkg::FN_CLEAR: begin
        pred_len = 0;
        for (int i = 0; i < fae_pkg::HEADER_BYTES && i < FB; i++) written_mask[i] = 1'b0;
      end
      fae_pkg::FN_PROTO: begin
        store_byte(0, r.offset[7:0]);
        grow_to(1);
      end
      fae_pkg::FN_SET8: begin
        if (r.offset < FB) begin
          store_byte(r.offset, r.value[7:0]);
          grow_to(r.offset + 1);
        end
      end
      fae_pkg::FN_SET16: store_u16(r.offset, r.value);
      fae_pkg::FN_PLEN: begin
        if (r.has_payload) store_u16(r.offset, r.payload_len);
      end
      fae_pkg::FN_APPEND: begin
        if (!run_open && (!r.has_payload || r.payload_len == 0)) begin
          // An empty or absent payload opens no run.
        end else if (!run_open && pred_len + r.payload_len > FB) begin
          err_state = fae_pkg::ERR_OVERFLOW;
        end else begin
          if (pred_len < FB) begin
            store_byte(pred_len, r.payload_byte);
            pred_len++;
          end
          run_open = !r.payload_last;
        end
      end
      fae_pkg::FN_SEND: begin
        if (pred_len != 0) begin
          for (int unsigned i = 0; i < pred_len; i++)
            pending_beats.push_back(beat_of(1'b1, written_mask[i] ? frame_mem[i] : 8'h00,
                                            i + 1 == pred_len));
          return;
        end
      end
      fae_pkg::FN_HALT: halt_seen = 1'b1;
      fae_pkg::FN_NOP, fae_pkg::FN_PRINT: ;
      default: err_state = fae_pkg::ERR_UNKNOWN;
    endcase
    pending_beats.push_back(beat_of(1'b0, 8'h00, 1'b1));
  endfunction

  function automatic fae_pkg::in_item_t req(logic [3:0] f, logic [15:0] off,
                                            logic [15:0] val, logic [7:0] pb,
                                            logic [15:0] pl, logic hp,
                                            logic lst, logic st);
    fae_pkg::in_item_t r;
    r.func          = f;
    r.offset        = off;
    r.value         = val;
    r.payload_byte  = pb;
    r.payload_len   = pl;
    r.has_payload   = hp;
    r.payload_last  = lst;
    r.program_start = st;
    return r;
  endfunction

  function automatic fae_pkg::out_item_t status_of(int len, logic [1:0] e, logic h);
    fae_pkg::out_item_t o;
    o              = '0;
    o.last         = 1'b1;
    o.frame_length = len[6:0];
    o.error_code   = e;
    o.halted       = h;
    return o;
  endfunction

  function automatic stim_row_t row_free(fae_pkg::in_item_t r);
    return '{r: r, fixed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t row_fixed(fae_pkg::in_item_t r, fae_pkg::out_item_t want);
    return '{r: r, fixed: 1'b1, want: want};
  endfunction

  function automatic fae_pkg::in_item_t random_req(logic [3:0] f);
    return req(f, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
               1'($urandom), 1'($urandom), 1'b0);
  endfunction

  function automatic int req_gap();
    int p;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 149) == 0) burst_left = 30;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offers one request, predicts it on acceptance, then idles for a random gap.
  task automatic issue(input fae_pkg::in_item_t r, input bit fixed = 1'b0,
                       input fae_pkg::out_item_t want = '0);
    int gap;
    cmd       <= r;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    predict_frame_cmd(r);
    if (fixed) pending_beats[pending_beats.size() - 1] = want;
    items_done++;
    gap = req_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  function automatic fae_pkg::in_item_t random_field();
    fae_pkg::in_item_t r;
    int                pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: r = random_req(fae_pkg::FN_PROTO);
      1, 2: begin
        r = random_req(fae_pkg::FN_SET8);
        if ($urandom_range(0, 9) != 0) r.offset = 16'($urandom_range(0, 70));
      end
      3, 4: begin
        r = random_req(fae_pkg::FN_SET16);
        if ($urandom_range(0, 9) != 0) r.offset = 16'($urandom_range(0, 66));
      end
      5, 6: begin
        r = random_req(fae_pkg::FN_PLEN);
        if ($urandom_range(0, 9) != 0) r.offset = 16'($urandom_range(0, 66));
        r.has_payload = ($urandom_range(0, 4) != 0);
      end
      7: r = random_req(fae_pkg::FN_CLEAR);
      8: r = random_req(fae_pkg::FN_NOP);
      default: r = random_req(fae_pkg::FN_PRINT);
    endcase
    if ($urandom_range(0, 39) == 0) r.program_start = 1'b1;
    return r;
  endfunction

  task automatic append_run();
    fae_pkg::in_item_t r;
    int                plen;
    int                count;
    if ($urandom_range(0, 9) == 0) plen = $urandom_range(40, 65535);
    else plen = $urandom_range(1, 16);
    count = (plen > 16) ? $urandom_range(1, 2) : plen;
    // Now and then the run is cut short or carries more bytes than announced.
    if ($urandom_range(0, 7) == 0) count = $urandom_range(1, 20);
    for (int k = 0; k < count; k++) begin
      r = random_req(fae_pkg::FN_APPEND);
      if (k == 0) begin
        r.has_payload = 1'b1;
        r.payload_len = 16'(plen);
      end
      r.payload_last = (k == count - 1);
      if (k > 0 && $urandom_range(0, 19) == 0) issue(random_req(fae_pkg::FN_NOP));
      issue(r);
    end
  endtask

  task automatic random_program();
    fae_pkg::in_item_t r;
    int                n_fields;
    r               = random_field();
    r.program_start = 1'b1;
    issue(r);
    n_fields = $urandom_range(0, 4);
    repeat (n_fields) issue(random_field());
    if ($urandom_range(0, 9) < 6) append_run();
    if ($urandom_range(0, 9) < 3) issue(random_field());
    if ($urandom_range(0, 9) < 8) issue(random_req(fae_pkg::FN_SEND));
    if ($urandom_range(0, 9) < 2) begin
      issue(random_req(4'($urandom_range(int'(fae_pkg::FN_HALT), 15))));
      issue(random_req(4'($urandom_range(0, 15))));
    end
  endtask

  task automatic check_field(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, want, got);
    end
  endtask

  task automatic check_beat(fae_pkg::out_item_t got);
    fae_pkg::out_item_t want;
    if (pending_beats.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %p", $time, got);
    end else begin
      want = pending_beats.pop_front();
      check_field("out_kind", want.out_kind, got.out_kind);
      check_field("frame_byte", want.frame_byte, got.frame_byte);
      check_field("last", want.last, got.last);
      check_field("frame_length", want.frame_length, got.frame_length);
      check_field("error_code", want.error_code, got.error_code);
      check_field("halted", want.halted, got.halted);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      check_beat(res);
      beats_seen++;
      if (res.out_kind && res.last) frames_sent++;
    end
  end

  // Result side: random stalls, a rare long open stretch, and one long hold-off on request.
  initial begin
    int stall;
    res_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        if ($urandom_range(0, 29) == 0) repeat (80) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = $urandom_range(0, 99);
        if (stall < 40) stall = 0;
        else if (stall < 92) stall = $urandom_range(1, 4);
        else stall = $urandom_range(20, 60);
        if (stall > 0) begin
          res_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t directed_rows [$];
    int        programs;
    errors      = 0;
    items_done  = 0;
    beats_seen  = 0;
    frames_sent = 0;
    burst_left  = 0;
    want_hold   = 1'b0;
    hold_done   = 1'b0;
    wipe_context();
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_rows.push_back(row_fixed(req(fae_pkg::FN_NOP, 0, 0, 0, 0, 0, 0, 1),
                                      status_of(0, fae_pkg::ERR_NONE, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_PROTO, 16'hFFAB, 16'hFFFF, 8'hFF,
                                         0, 0, 0, 0)));
    directed_rows.push_back(row_fixed(req(fae_pkg::FN_SET8, 63, 16'hFFFF, 0, 0, 0, 0, 0),
                                      status_of(64, fae_pkg::ERR_NONE, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_SET8, 16'hFFFF, 16'h00FF, 0,
                                         0, 0, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_SET16, 62, 16'hA55A, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_SET16, 63, 16'h1234, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_PLEN, 2, 0, 0, 16'hFFFF, 0, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_PLEN, 2, 0, 0, 16'hFFFF, 1, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_SEND, 0, 0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row_fixed(req(fae_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0, 0),
                                      status_of(0, fae_pkg::ERR_NONE, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_SET16, 4, 16'h00FF, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_APPEND, 0, 0, 8'hFF, 3, 0, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_APPEND, 0, 0, 8'hFF, 0, 1, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_APPEND, 0, 0, 8'h11, 3, 1, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_APPEND, 0, 0, 8'h22, 3, 1, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_PRINT, 0, 0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_APPEND, 0, 0, 8'h33, 1, 1, 1, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_SEND, 0, 0, 0, 0, 0, 0, 0)));
    // An open run keeps appending past the buffer end; the extra byte is dropped.
    directed_rows.push_back(row_free(req(fae_pkg::FN_SET8, 61, 16'h005A, 0, 0, 0, 0, 1)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_APPEND, 0, 0, 8'h01, 2, 1, 0, 0)));
    directed_rows.push_back(row_free(req(fae_pkg::FN_APPEND, 0, 0, 8'h02, 2, 1, 0, 0)));
    directed_rows.push_back(row_fixed(req(fae_pkg::FN_APPEND, 0, 0, 8'h03, 2, 1, 1, 0),
                                      status_of(64, fae_pkg::ERR_NONE, 0)));
    directed_rows.push_back(row_fixed(req(fae_pkg::FN_SEND, 0, 0, 0, 0, 0, 0, 1),
                                      status_of(0, fae_pkg::ERR_NONE, 0)));
    directed_rows.push_back(row_fixed(req(fae_pkg::FN_APPEND, 0, 0, 8'h77, 65, 1, 1, 1),
                                      status_of(0, fae_pkg::ERR_OVERFLOW, 0)));
    directed_rows.push_back(row_fixed(req(fae_pkg::FN_SEND, 0, 0, 0, 0, 0, 0, 0),
                                      status_of(0, fae_pkg::ERR_OVERFLOW, 0)));
    directed_rows.push_back(row_fixed(req(4'hF, 0, 0, 0, 0, 0, 0, 1),
                                      status_of(0, fae_pkg::ERR_UNKNOWN, 0)));
    directed_rows.push_back(row_fixed(req(fae_pkg::FN_HALT, 0, 0, 0, 0, 0, 0, 1),
                                      status_of(0, fae_pkg::ERR_NONE, 1)));
    directed_rows.push_back(row_fixed(req(fae_pkg::FN_SET16, 0, 16'hFFFF, 0, 0, 1, 1, 0),
                                      status_of(0, fae_pkg::ERR_NONE, 1)));

    foreach (directed_rows[i])
      issue(directed_rows[i].r, directed_rows[i].fixed, directed_rows[i].want);
    n_directed = items_done;
    drain();

    programs = 0;
    while (items_done < n_directed + RANDOM_ITEMS) begin
      if (!hold_done && items_done > n_directed + 120) begin
        // Back-to-back requests against a blocked result side fill the queue.
        hold_done  = 1'b1;
        want_hold  = 1'b1;
        burst_left = 24;
      end
      random_program();
      programs++;
      if (programs % 6 == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d directed, %0d random programs), %0d result beats,",
             items_done, n_directed, programs, beats_seen);
    $display("%0d frames transmitted, with halts, overflows and unknown commands mixed in.",
             frames_sent);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
